>>> design/morse_duration_decoder_core_assert.svh
// Assertion macros shared by the Morse decoder modules (clk / rst in scope).
`ifndef MORSE_DURATION_DECODER_CORE_ASSERT_SVH
`define MORSE_DURATION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdd: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdd: next-cycle check failed");

`endif

>>> design/mdd_pkg.sv
// Shared types, constants and letter lookup for the Morse duration decoder.
`timescale 1ns / 1ps

package mdd_pkg;

  localparam int DUR_W   = 32;
  localparam int UNIT_W  = 16;
  localparam int CHAR_W  = 7;
  localparam int BITS_W  = 4;
  localparam int COUNT_W = 3;

  // Element count limits: four elements fit, five means too many
  localparam logic [COUNT_W-1:0] MAX_ELEMS  = 3'd4;
  localparam logic [COUNT_W-1:0] OVER_ELEMS = 3'd5;

  // Configuration register indexes
  localparam logic REG_MARK_UNIT = 1'b0;
  localparam logic REG_GAP_UNIT  = 1'b1;

  localparam logic [UNIT_W-1:0] MARK_UNIT_RST = 16'd100;
  localparam logic [UNIT_W-1:0] GAP_UNIT_RST  = 16'd130;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h2D;

  // Letter tables, first element most significant, dash = 1
  localparam logic [CHAR_W-1:0] LEN1_TAB [2]  = '{7'h45, 7'h54};
  localparam logic [CHAR_W-1:0] LEN2_TAB [4]  = '{7'h49, 7'h41, 7'h4E, 7'h4D};
  localparam logic [CHAR_W-1:0] LEN3_TAB [8]  = '{7'h53, 7'h55, 7'h52, 7'h57,
                                                 7'h44, 7'h4B, 7'h47, 7'h4F};
  localparam logic [CHAR_W-1:0] LEN4_TAB [16] = '{7'h48, 7'h56, 7'h46, 7'h2D,
                                                 7'h4C, 7'h2D, 7'h50, 7'h4A,
                                                 7'h42, 7'h58, 7'h43, 7'h59,
                                                 7'h5A, 7'h51, 7'h2D, 7'h2D};

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             end_of_message;
  } item_t;

  // Result set handed from the decoder to the result register
  typedef struct packed {
    logic              load;
    logic [CHAR_W-1:0] letter;
    logic              space;
  } res_set_t;

  function automatic logic [CHAR_W-1:0] lookup_letter(input logic [BITS_W-1:0]  bits,
                                                      input logic [COUNT_W-1:0] count);
    logic [CHAR_W-1:0] ch;
    case (count)
      3'd1:    ch = LEN1_TAB[bits[0]];
      3'd2:    ch = LEN2_TAB[bits[1:0]];
      3'd3:    ch = LEN3_TAB[bits[2:0]];
      3'd4:    ch = LEN4_TAB[bits];
      default: ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

endpackage

>>> design/mdd_in_if.sv
// Input channel: key interval durations with end-of-message flag.
`timescale 1ns / 1ps

interface mdd_in_if import mdd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration;
  logic             end_of_message;

  modport source (output valid, duration, end_of_message, input ready);
  modport sink   (input valid, duration, end_of_message, output ready);
endinterface

>>> design/mdd_out_if.sv
// Output channel: decoded characters.
`timescale 1ns / 1ps

interface mdd_out_if import mdd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_in_run;

  modport source (output valid, character, last_in_run, input ready);
  modport sink   (input valid, character, last_in_run, output ready);
endinterface

>>> design/morse_duration_decoder_core.sv
// Top level of the Morse duration decoder.
`timescale 1ns / 1ps

// Takes alternating key-down and key-up durations (first one key-down) and
// returns ASCII letters, a space after a word gap, and '-' for empty, over-long
// or unknown letters. Each interval is registered on input and decoded from
// that register straight into the result register; it is taken only while
// the result register is free. One giving a letter and a space keeps the
// result register busy until the space is being transferred, which holds off
// the next interval. A stalled result holds the input stage as well. Write
// mark_unit (index 0) and gap_unit (index 1) only while no interval is in
// flight.
module morse_duration_decoder_core import mdd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [UNIT_W-1:0] cfg_data,
  mdd_in_if.sink            din,
  mdd_out_if.source         dout
);

  logic     take;
  logic     held;
  logic     free;
  item_t    item;
  res_set_t res;

  mdd_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .take (take),
    .held (held),
    .item (item)
  );

  mdd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .held      (held),
    .item      (item),
    .free      (free),
    .take      (take),
    .res       (res)
  );

  mdd_out_stage u_out_stage (
    .clk  (clk),
    .rst  (rst),
    .res  (res),
    .free (free),
    .dout (dout)
  );

endmodule

>>> design/mdd_in_stage.sv
// Input register holding one key interval until the decoder takes it.
`timescale 1ns / 1ps

module mdd_in_stage import mdd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mdd_in_if.sink    din,
  input  logic      take,
  output logic      held,
  output item_t     item
);

  logic  ival;
  item_t item_q;

  assign din.ready = !ival || take;
  assign held      = ival;
  assign item      = item_q;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      ival <= 1'b0;
    end else if (din.valid && din.ready) begin
      ival <= 1'b1;
    end else if (take) begin
      ival <= 1'b0;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      item_q.duration       <= din.duration;
      item_q.end_of_message <= din.end_of_message;
    end
  end

endmodule

>>> design/mdd_decode.sv
// Interval classification, letter gathering and lookup, plus unit registers.
`timescale 1ns / 1ps

module mdd_decode import mdd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [UNIT_W-1:0] cfg_data,
  input  logic              held,
  input  item_t             item,
  input  logic              free,
  output logic              take,
  output res_set_t          res
);

  logic [UNIT_W-1:0]  mark_unit;
  logic [UNIT_W-1:0]  gap_unit;
  logic               phase_is_gap;
  logic [BITS_W-1:0]  element_bits;
  logic [COUNT_W-1:0] element_count;

  logic               phase_is_gap_next;
  logic [BITS_W-1:0]  element_bits_next;
  logic [COUNT_W-1:0] element_count_next;

  logic [UNIT_W:0]    mark_twice;
  logic [UNIT_W:0]    gap_twice;
  logic [UNIT_W+2:0]  gap_seven;
  logic               dash;
  logic               letter_gap;
  logic               word_gap;
  logic               emit_letter;
  logic               emit_space;
  logic [BITS_W-1:0]  upd_bits;
  logic [COUNT_W-1:0] upd_count;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_unit <= MARK_UNIT_RST;
      gap_unit  <= GAP_UNIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MARK_UNIT: mark_unit <= cfg_data;
        REG_GAP_UNIT:  gap_unit  <= cfg_data;
        default:       mark_unit <= mark_unit;
      endcase
    end
  end

  // Classify the interval against scaled units
  assign mark_twice = {mark_unit, 1'b0};
  assign gap_twice  = {gap_unit, 1'b0};
  assign gap_seven  = {gap_unit, 3'b000} - (UNIT_W+3)'(gap_unit);
  assign dash       = item.duration >= DUR_W'(mark_twice);
  assign letter_gap = item.duration >= DUR_W'(gap_twice);
  assign word_gap   = item.duration >= DUR_W'(gap_seven);

  // Gather the element on a mark
  always_comb begin
    upd_bits  = element_bits;
    upd_count = element_count;
    if (!phase_is_gap) begin
      if (element_count < MAX_ELEMS) begin
        upd_bits = {element_bits[BITS_W-2:0], dash};
      end
      if (element_count < OVER_ELEMS) begin
        upd_count = element_count + 3'd1;
      end
    end
  end

  assign emit_letter = item.end_of_message || (phase_is_gap && letter_gap);
  assign emit_space  = phase_is_gap && word_gap;
  assign take        = held && free;

  assign res.load   = take && emit_letter;
  assign res.letter = lookup_letter(upd_bits, upd_count);
  assign res.space  = emit_space;

  // Next letter state: clear on emit or end of message
  always_comb begin
    element_bits_next  = upd_bits;
    element_count_next = upd_count;
    if (emit_letter) begin
      element_bits_next  = '0;
      element_count_next = '0;
    end
    phase_is_gap_next = item.end_of_message ? 1'b0 : !phase_is_gap;
  end

  // Advance letter state on each taken interval
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_is_gap  <= 1'b0;
      element_bits  <= '0;
      element_count <= '0;
    end else if (take) begin
      phase_is_gap  <= phase_is_gap_next;
      element_bits  <= element_bits_next;
      element_count <= element_count_next;
    end
  end

  `include "morse_duration_decoder_core_assert.svh"

  `MDD_ASSERT_IMP(a_count_range, 1'b1, element_count <= OVER_ELEMS)
  `MDD_ASSERT_NXT(a_eom_resets, take && item.end_of_message,
                  !phase_is_gap && element_count == '0 && element_bits == '0)
  `MDD_ASSERT_IMP(a_space_has_letter, take && res.space, res.load)

endmodule

>>> design/mdd_out_stage.sv
// Result register: presents the letter, then a following space if any.
`timescale 1ns / 1ps

module mdd_out_stage import mdd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_set_t  res,
  output logic      free,
  mdd_out_if.source dout
);

  logic              out_valid;
  logic              space_pending;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              xfer;

  assign xfer             = out_valid && dout.ready;
  assign free             = !out_valid || (dout.ready && !space_pending);
  assign dout.valid       = out_valid;
  assign dout.character   = out_char;
  assign dout.last_in_run = out_last;

  // Control: load a new set, move to the space, or drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      space_pending <= 1'b0;
    end else if (res.load) begin
      out_valid     <= 1'b1;
      space_pending <= res.space;
    end else if (xfer) begin
      out_valid     <= space_pending;
      space_pending <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res.load) begin
      out_char <= res.letter;
      out_last <= !res.space;
    end else if (xfer && space_pending) begin
      out_char <= CHAR_SPACE;
      out_last <= 1'b1;
    end
  end

  `include "morse_duration_decoder_core_assert.svh"

  `MDD_ASSERT_IMP(a_pending_needs_valid, space_pending, out_valid && !out_last)
  `MDD_ASSERT_NXT(a_space_follows, xfer && space_pending,
                  out_valid && out_char == CHAR_SPACE && out_last)
  `MDD_ASSERT_IMP(a_load_only_free, res.load, free)

endmodule

>>> dv/tb_morse_duration_decoder_core.sv
// Self-checking testbench for the Morse duration decoder core: random key timing against a predictor.
`timescale 1ns / 1ps

module tb_morse_duration_decoder_core;
  import mdd_pkg::*;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  SETTLE_CYCLES = 8;
  localparam int  RAND_ITEMS = 240;

  typedef enum {GAP_INTRA, GAP_LETTER, GAP_WORD} gap_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_in_run;
  } char_exp_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [UNIT_W-1:0] cfg_data;

  mdd_in_if  din_if ();
  mdd_out_if dout_if ();

  morse_duration_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  // Pending key intervals and the characters they should decode to
  item_t     pend_items [$];
  char_exp_t exp_chars [$];

  int send_idle;
  int recv_idle;
  int mismatches;
  int cycle_count;

  // Predictor state
  logic [UNIT_W-1:0]  pr_mark_unit;
  logic [UNIT_W-1:0]  pr_gap_unit;
  logic               pr_in_gap;
  logic [BITS_W-1:0]  pr_bits;
  logic [COUNT_W-1:0] pr_count;

  // Stimulus-side view of the units and the phase
  logic [UNIT_W-1:0] gen_mark_unit;
  logic [UNIT_W-1:0] gen_gap_unit;
  logic              gen_in_gap;

  always #6 clk = ~clk;

  // Look up a letter from gathered elements, first element most significant
  function automatic logic [CHAR_W-1:0] letter_of(input logic [BITS_W-1:0]  bits,
                                                   input logic [COUNT_W-1:0] count);
    string t1 = "ET";
    string t2 = "IANM";
    string t3 = "SURWDKGO";
    string t4 = "HVF-L-PJBXCYZQ--";
    byte   b;
    case (count)
      3'd1:    b = t1[bits[0]];
      3'd2:    b = t2[bits[1:0]];
      3'd3:    b = t3[bits[2:0]];
      3'd4:    b = t4[bits];
      default: b = byte'(CHAR_UNKNOWN);
    endcase
    return b[CHAR_W-1:0];
  endfunction

  // Advance the predictor by one accepted interval and queue its characters
  task automatic decode_interval(input logic [DUR_W-1:0] dur, input logic eom);
    logic [63:0]       d;
    logic [63:0]       two_mark;
    logic [63:0]       two_gap;
    logic [63:0]       seven_gap;
    logic              dash;
    logic              emit_letter;
    logic              emit_space;
    char_exp_t         e;
    d         = {32'b0, dur};
    two_mark  = {48'b0, pr_mark_unit} << 1;
    two_gap   = {48'b0, pr_gap_unit} << 1;
    seven_gap = {48'b0, pr_gap_unit} * 64'd7;
    emit_letter = eom;
    emit_space  = 1'b0;
    if (!pr_in_gap) begin
      dash = (d >= two_mark);
      if (pr_count < MAX_ELEMS) pr_bits = {pr_bits[BITS_W-2:0], dash};
      if (pr_count < OVER_ELEMS) pr_count = pr_count + 3'd1;
    end else begin
      if (d >= two_gap) emit_letter = 1'b1;
      if (d >= seven_gap) emit_space = 1'b1;
    end
    if (emit_letter) begin
      e.character   = letter_of(pr_bits, pr_count);
      e.last_in_run = !emit_space;
      exp_chars.push_back(e);
      pr_bits  = '0;
      pr_count = '0;
    end
    if (emit_space) begin
      e.character   = CHAR_SPACE;
      e.last_in_run = 1'b1;
      exp_chars.push_back(e);
    end
    if (eom) begin
      pr_in_gap = 1'b0;
      pr_bits   = '0;
      pr_count  = '0;
    end else begin
      pr_in_gap = !pr_in_gap;
    end
  endtask

  task automatic report_mismatch(input string what, input char_exp_t exp_c,
                                 input char_exp_t act_c);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at cycle %0d: expected char %h last %b, got char %h last %b",
               what, cycle_count, exp_c.character, exp_c.last_in_run,
               act_c.character, act_c.last_in_run);
  endtask

  // Track configuration, check each output transfer, predict each input transfer
  always @(posedge clk) begin : check_proc
    char_exp_t act_c;
    char_exp_t exp_c;
    if (rst) begin
      pr_mark_unit <= MARK_UNIT_RST;
      pr_gap_unit  <= GAP_UNIT_RST;
      pr_in_gap    = 1'b0;
      pr_bits      = '0;
      pr_count     = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MARK_UNIT) pr_mark_unit <= cfg_data;
        else pr_gap_unit <= cfg_data;
      end
      if (dout_if.valid && dout_if.ready) begin
        act_c.character   = dout_if.character;
        act_c.last_in_run = dout_if.last_in_run;
        if (exp_chars.size() == 0) begin
          exp_c = '0;
          report_mismatch("unexpected", exp_c, act_c);
        end else begin
          exp_c = exp_chars.pop_front();
          if (act_c.character !== exp_c.character || act_c.last_in_run !== exp_c.last_in_run)
            report_mismatch("field", exp_c, act_c);
        end
      end
      if (din_if.valid && din_if.ready)
        decode_interval(din_if.duration, din_if.end_of_message);
    end
  end

  // Drive the input channel from the pending queue
  always @(posedge clk) begin : drive_proc
    item_t it;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || din_if.ready) begin
      if (pend_items.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = pend_items.pop_front();
        din_if.valid          <= 1'b1;
        din_if.duration       <= it.duration;
        din_if.end_of_message <= it.end_of_message;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  // Stall the output channel at random
  always @(posedge clk) begin
    if (rst) dout_if.ready <= 1'b0;
    else dout_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_item(input logic [DUR_W-1:0] dur, input logic eom);
    item_t it;
    it.duration       = dur;
    it.end_of_message = eom;
    pend_items.push_back(it);
    gen_in_gap = eom ? 1'b0 : !gen_in_gap;
  endtask

  // Random value in [lo, hi], often one of the two ends
  function automatic logic [DUR_W-1:0] pick_between(input logic [63:0] lo,
                                                     input logic [63:0] hi);
    logic [63:0] top;
    logic [63:0] bot;
    top = (hi > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : hi;
    bot = (lo > top) ? top : lo;
    case ($urandom_range(3))
      0:       return bot[31:0];
      1:       return top[31:0];
      default: return $urandom_range(top[31:0], bot[31:0]);
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] mark_dur(input logic dash);
    logic [63:0] m2;
    m2 = {48'b0, gen_mark_unit} << 1;
    if ($urandom_range(7) == 0) return $urandom;
    if (dash) return pick_between(m2, m2 * 3 + 5);
    return pick_between(0, (m2 == 0) ? 64'd0 : m2 - 1);
  endfunction

  function automatic logic [DUR_W-1:0] gap_dur(input gap_kind_t kind);
    logic [63:0] g2;
    logic [63:0] g7;
    g2 = {48'b0, gen_gap_unit} << 1;
    g7 = {48'b0, gen_gap_unit} * 64'd7;
    case (kind)
      GAP_INTRA:  return pick_between(0, (g2 == 0) ? 64'd0 : g2 - 1);
      GAP_LETTER: return pick_between(g2, (g7 == 0) ? 64'd0 : g7 - 1);
      default: begin
        if ($urandom_range(7) == 0) return $urandom;
        return pick_between(g7, g7 * 2 + 5);
      end
    endcase
  endfunction

  // Queue well-formed messages with random content, some noise and broken endings
  task automatic gen_messages(input int n_items);
    int target;
    int letters;
    int elems;
    target = pend_items.size() + n_items;
    while (pend_items.size() < target) begin
      letters = $urandom_range(1, 5);
      for (int l = 0; l < letters; l++) begin
        elems = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        for (int e = 0; e < elems; e++) begin
          if ($urandom_range(19) == 0) add_item($urandom, 1'($urandom_range(1)));
          if (gen_in_gap) add_item(gap_dur(gap_kind_t'($urandom_range(2))), 1'b0);
          add_item(mark_dur(1'($urandom_range(1))), 1'b0);
          if (e < elems - 1) add_item(gap_dur(GAP_INTRA), 1'b0);
        end
        if (l < letters - 1)
          add_item(gap_dur(($urandom_range(3) == 0) ? GAP_WORD : GAP_LETTER), 1'b0);
      end
      // End the message: flush on a gap, a plain word gap, or flush on a mark
      case ($urandom_range(2))
        0: add_item(gap_dur(gap_kind_t'($urandom_range(2))), 1'b1);
        1: add_item(gap_dur(GAP_WORD), 1'b0);
        default: begin
          add_item(gap_dur(GAP_LETTER), 1'b0);
          add_item(mark_dur(1'($urandom_range(1))), 1'b1);
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic idx, input logic [UNIT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_MARK_UNIT) gen_mark_unit = value;
    else gen_gap_unit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_units(input logic [UNIT_W-1:0] mark_u, input logic [UNIT_W-1:0] gap_u);
    write_reg(REG_MARK_UNIT, mark_u);
    write_reg(REG_GAP_UNIT, gap_u);
  endtask

  // Hold until every interval is transferred and every character has come back
  task automatic drain();
    do @(posedge clk);
    while (pend_items.size() != 0 || din_if.valid || exp_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_MARK_UNIT;
    cfg_data              = '0;
    din_if.valid          = 1'b0;
    din_if.duration       = '0;
    din_if.end_of_message = 1'b0;
    dout_if.ready         = 1'b0;
    send_idle             = 14;
    recv_idle             = 57;
    mismatches            = 0;
    cycle_count           = 0;
    gen_mark_unit         = MARK_UNIT_RST;
    gen_gap_unit          = GAP_UNIT_RST;
    gen_in_gap            = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed intervals at reset units: boundaries of each class
    add_item(32'd0, 1'b0);
    add_item(32'd259, 1'b0);
    add_item(32'd200, 1'b0);
    add_item(32'd260, 1'b0);
    add_item(32'd199, 1'b0);
    add_item(32'd909, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'd910, 1'b1);
    // Too many elements, flushed on the fifth mark
    for (int i = 0; i < 4; i++) begin
      add_item(32'd0, 1'b0);
      add_item(32'd0, 1'b0);
    end
    add_item(32'd0, 1'b1);
    // Unmapped four-element code, all dashes
    for (int i = 0; i < 3; i++) begin
      add_item(32'd200, 1'b0);
      add_item(32'd0, 1'b0);
    end
    add_item(32'd200, 1'b1);
    gen_messages(200);
    drain();

    set_units(16'd1, 16'd1);
    gen_messages(RAND_ITEMS);
    drain();

    send_idle <= 57;
    recv_idle <= 14;
    set_units(16'hFFFF, 16'hFFFF);
    gen_messages(RAND_ITEMS);
    drain();

    // Zero units: every mark a dash, every gap a word gap
    set_units(16'd0, 16'd0);
    gen_messages(RAND_ITEMS);
    drain();

    send_idle <= 0;
    recv_idle <= 0;
    set_units(16'($urandom_range(2, 300)), 16'($urandom_range(2, 300)));
    gen_messages(RAND_ITEMS);
    drain();

    set_units(16'hFFFF, 16'd1);
    gen_messages(RAND_ITEMS);
    drain();

    if (mismatches == 0 && exp_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/mdd_pkg.sv
design/mdd_in_if.sv
design/mdd_out_if.sv
design/mdd_in_stage.sv
design/mdd_decode.sv
design/mdd_out_stage.sv
design/morse_duration_decoder_core.sv
dv/tb_morse_duration_decoder_core.sv
